// File: sv/cld_pkg.sv
// ----------------------------------------------------------------------------
// cld_pkg
// Shared types and constants of the content-length deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package cld_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int CFG_W           = 32;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;
    localparam int BODY_LEN_W      = 32;
    localparam int ERR_W           = 3;
    localparam int ACC_W           = 64;

    localparam logic [CFG_W-1:0] MAX_BODY_RESET = 32'd67108864;

    // "Content-Length"
    localparam logic [3:0] NAME_LEN = 4'd14;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_HALT   = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        NS_LEAD   = 3'd0,
        NS_MATCH  = 3'd1,
        NS_TRAIL  = 3'd2,
        NS_MISS   = 3'd3,
        NS_VALUE  = 3'd4,
        NS_IGNORE = 3'd5
    } t_name_stage;

    typedef enum logic [1:0] {
        VS_LEAD   = 2'd0,
        VS_DIGITS = 2'd1,
        VS_TRAIL  = 2'd2
    } t_value_stage;

    typedef enum logic [KIND_W-1:0] {
        K_START = 2'd0,
        K_BODY  = 2'd1,
        K_ERROR = 2'd2,
        K_END   = 2'd3
    } t_kind;

    typedef enum logic [ERR_W-1:0] {
        ERR_INVALID     = 3'd0,
        ERR_TOO_LARGE   = 3'd1,
        ERR_MISSING     = 3'd2,
        ERR_EOF_HEADERS = 3'd3,
        ERR_EOF_BODY    = 3'd4
    } t_err_code;

    // per-line parser state
    typedef struct packed {
        logic               empty;
        t_name_stage        name_stage;
        logic [3:0]         name_pos;
        t_value_stage       value_stage;
        logic [ACC_W-1:0]   acc;
        logic               overflow;
        logic               bad;
    } t_line;

    localparam t_line LINE_CLEAR = '{
        empty:       1'b1,
        name_stage:  NS_LEAD,
        name_pos:    4'd0,
        value_stage: VS_LEAD,
        acc:         '0,
        overflow:    1'b0,
        bad:         1'b0
    };

    // lowercase header name, indexed by match position
    function automatic logic [7:0] name_char(input logic [3:0] pos);
        logic [7:0] ch;
        unique case (pos)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

`default_nettype wire

// File: sv/cld_if.sv
// ----------------------------------------------------------------------------
// cld_in_if / cld_out_if
// Valid/ready channels for stream items and deframer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cld_in_if
    import cld_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    logic              end_of_stream;

    modport source (output valid, output stream_byte, output end_of_stream, input ready);
    modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface cld_out_if
    import cld_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [KIND_W-1:0]     kind;
    logic [BODY_LEN_W-1:0] body_length;
    logic [BYTE_W-1:0]     body_data;
    logic                  last_byte;
    logic [ERR_W-1:0]      error_code;

    modport source (output valid, output kind, output body_length, output body_data,
                    output last_byte, output error_code, input ready);
    modport sink   (input valid, input kind, input body_length, input body_data,
                    input last_byte, input error_code, output ready);
endinterface

`default_nettype wire

// File: sv/content_length_deframer_unit.sv
// ----------------------------------------------------------------------------
// content_length_deframer_unit
// Splits a byte stream into Content-Length framed messages.
// ----------------------------------------------------------------------------
// Each stream item is taken on a handshake and its result, if any, appears in
// the output register on the next cycle; one item per cycle is sustained as
// long as the result side keeps taking results. The per-byte header parser
// (name match, decimal accumulate with a 64-bit carry check) and the body
// counter all sit between the parser state registers and the result
// register. Items that give no result (most header bytes) still use the
// handshake. After an error or a clean end of stream all items are taken and
// dropped until reset. max_body_bytes may be written only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module content_length_deframer_unit
    import cld_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [CFG_W-1:0]  i_cfg_wdata,
    cld_in_if.sink           i_in,
    cld_out_if.source        o_res
);

    // held length never exceeds the smaller of 32 bits and LENGTH_BITS
    localparam int HW = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam logic [CFG_W-1:0] LEN_CAP = (LENGTH_BITS >= 32) ? 32'hFFFF_FFFF
                                         : 32'((64'd1 << LENGTH_BITS) - 64'd1);

    function automatic t_line match_name(input t_line s, input logic [7:0] c);
        t_line r;
        r = s;
        if (s.name_pos < NAME_LEN && to_lower(c) == name_char(s.name_pos)) begin
            r.name_pos   = s.name_pos + 4'd1;
            r.name_stage = NS_MATCH;
        end else begin
            r.name_stage = NS_MISS;
        end
        return r;
    endfunction

    function automatic t_line feed_value(input t_line s, input logic [7:0] c);
        t_line           r;
        logic [ACC_W+3:0] sum;
        r   = s;
        sum = {1'b0, s.acc, 3'b0} + {3'b0, s.acc, 1'b0} + {60'b0, c - CH_ZERO};
        if (is_ws(c)) begin
            if (s.value_stage == VS_DIGITS) begin
                r.value_stage = VS_TRAIL;
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (s.value_stage == VS_TRAIL) begin
                r.bad = 1'b1;
            end else begin
                r.value_stage = VS_DIGITS;
                if (s.overflow || sum[ACC_W+3:ACC_W] != 4'd0) begin
                    r.overflow = 1'b1;
                end else begin
                    r.acc = sum[ACC_W-1:0];
                end
            end
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

    function automatic t_line feed_char(input t_line s, input logic [7:0] c);
        t_line r;
        r       = s;
        r.empty = 1'b0;
        unique case (s.name_stage)
            NS_LEAD: begin
                if (c == CH_COLON) begin
                    r.name_stage = NS_IGNORE;
                end else if (!is_ws(c)) begin
                    r = match_name(r, c);
                end
            end
            NS_MATCH: begin
                if (is_ws(c)) begin
                    r.name_stage = NS_TRAIL;
                end else if (c == CH_COLON) begin
                    r.name_stage = (s.name_pos == NAME_LEN) ? NS_VALUE : NS_IGNORE;
                end else begin
                    r = match_name(r, c);
                end
            end
            NS_TRAIL: begin
                if (c == CH_COLON) begin
                    r.name_stage = (s.name_pos == NAME_LEN) ? NS_VALUE : NS_IGNORE;
                end else if (!is_ws(c)) begin
                    r.name_stage = NS_MISS;
                end
            end
            NS_MISS: begin
                if (c == CH_COLON) begin
                    r.name_stage = NS_IGNORE;
                end
            end
            NS_VALUE: r = feed_value(r, c);
            default:  r = r;
        endcase
        return r;
    endfunction

    t_phase            r_phase, n_phase;
    logic              r_pending_cr, n_pending_cr;
    logic              r_started, n_started;
    t_line             r_line, n_line;
    logic              r_seen, n_seen;
    logic [HW-1:0]     r_held, n_held;
    logic [HW-1:0]     r_remain, n_remain;
    logic [CFG_W-1:0]  r_max_body;

    logic                  r_out_valid;
    t_kind                 r_kind;
    logic [BODY_LEN_W-1:0] r_body_length;
    logic [BYTE_W-1:0]     r_body_data;
    logic                  r_last_byte;
    t_err_code             r_error_code;

    logic                  accept;
    logic                  res_valid;
    t_kind                 res_kind;
    logic [BODY_LEN_W-1:0] res_length;
    logic [BYTE_W-1:0]     res_data;
    logic                  res_last;
    t_err_code             res_code;
    logic [CFG_W-1:0]      limit;
    t_line                 line_cr;
    logic [7:0]            c;

    assign i_in.ready = !r_out_valid || o_res.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.stream_byte;
    assign limit      = (r_max_body > LEN_CAP) ? LEN_CAP : r_max_body;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_pending_cr <= 1'b0;
            r_started    <= 1'b0;
            r_line       <= LINE_CLEAR;
            r_seen       <= 1'b0;
            r_held       <= '0;
            r_remain     <= '0;
        end else if (accept) begin
            r_phase      <= n_phase;
            r_pending_cr <= n_pending_cr;
            r_started    <= n_started;
            r_line       <= n_line;
            r_seen       <= n_seen;
            r_held       <= n_held;
            r_remain     <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body <= MAX_BODY_RESET;
        end else if (i_cfg_we) begin
            r_max_body <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_pending_cr = r_pending_cr;
        n_started    = r_started;
        n_line       = r_line;
        n_seen       = r_seen;
        n_held       = r_held;
        n_remain     = r_remain;
        res_valid    = 1'b0;
        res_kind     = K_START;
        res_length   = '0;
        res_data     = '0;
        res_last     = 1'b0;
        res_code     = ERR_INVALID;
        line_cr      = r_pending_cr ? feed_char(r_line, CH_CR) : r_line;

        unique case (r_phase)
            PH_BODY: begin
                res_valid = 1'b1;
                if (i_in.end_of_stream) begin
                    n_phase  = PH_HALT;
                    res_kind = K_ERROR;
                    res_code = ERR_EOF_BODY;
                end else begin
                    n_remain = r_remain - HW'(1);
                    res_kind = K_BODY;
                    res_data = c;
                    if (n_remain == '0) begin
                        n_phase  = PH_HEADER;
                        res_last = 1'b1;
                    end
                end
            end
            PH_HEADER: begin
                if (i_in.end_of_stream) begin
                    res_valid = 1'b1;
                    n_phase   = PH_HALT;
                    if (r_started) begin
                        res_kind = K_ERROR;
                        res_code = ERR_EOF_HEADERS;
                    end else begin
                        res_kind = K_END;
                    end
                end else if (c == CH_LF) begin
                    n_started    = 1'b1;
                    n_pending_cr = 1'b0;
                    n_line       = LINE_CLEAR;
                    if (r_line.empty) begin
                        // blank line closes the header block
                        res_valid = 1'b1;
                        if (!r_seen) begin
                            n_phase  = PH_HALT;
                            res_kind = K_ERROR;
                            res_code = ERR_MISSING;
                        end else begin
                            res_kind   = K_START;
                            res_length = BODY_LEN_W'(r_held);
                            n_started  = 1'b0;
                            n_seen     = 1'b0;
                            n_held     = '0;
                            n_remain   = r_held;
                            n_phase    = (r_held != '0) ? PH_BODY : PH_HEADER;
                        end
                    end else if (r_line.name_stage == NS_VALUE) begin
                        if (r_line.bad || r_line.value_stage == VS_LEAD
                            || r_line.overflow) begin
                            res_valid = 1'b1;
                            n_phase   = PH_HALT;
                            res_kind  = K_ERROR;
                            res_code  = ERR_INVALID;
                        end else if (r_line.acc > {32'b0, limit}) begin
                            res_valid = 1'b1;
                            n_phase   = PH_HALT;
                            res_kind  = K_ERROR;
                            res_code  = ERR_TOO_LARGE;
                        end else begin
                            n_seen = 1'b1;
                            n_held = r_line.acc[HW-1:0];
                        end
                    end
                end else begin
                    n_started = 1'b1;
                    if (c == CH_CR) begin
                        n_pending_cr = 1'b1;
                        n_line       = line_cr;
                    end else begin
                        n_pending_cr = 1'b0;
                        n_line       = feed_char(line_cr, c);
                    end
                end
            end
            PH_HALT: begin
                n_phase = PH_HALT;
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res_valid) begin
            r_kind        <= res_kind;
            r_body_length <= res_length;
            r_body_data   <= res_data;
            r_last_byte   <= res_last;
            r_error_code  <= res_code;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_kind;
    assign o_res.body_length = r_body_length;
    assign o_res.body_data   = r_body_data;
    assign o_res.last_byte   = r_last_byte;
    assign o_res.error_code  = r_error_code;

endmodule

`default_nettype wire
